FILE: design/lapsh_pkg.sv
`timescale 1ns / 1ps

package lapsh_pkg;

  // Line store geometry
  localparam int unsigned MaxWidth = 4096;
  localparam int unsigned ColW     = $clog2(MaxWidth);

  // Field and register widths
  localparam int unsigned PixW   = 8;
  localparam int unsigned WidthW = 13;
  localparam int unsigned RowW   = 16;
  localparam int unsigned CfgW   = 16;

  // Kernel arithmetic: 5*255 needs 11 bits, plus sign
  localparam int unsigned SharpGain = 5;
  localparam int unsigned AccW      = PixW + 4;

  // Register reset values and size limits
  localparam logic [WidthW-1:0] WidthReset  = WidthW'(640);
  localparam logic [RowW-1:0]   HeightReset = RowW'(480);
  localparam logic [WidthW-1:0] WidthMin    = WidthW'(3);
  localparam logic [WidthW-1:0] WidthMax    = WidthW'(MaxWidth);
  localparam logic [RowW-1:0]   HeightMin   = RowW'(3);

  typedef enum logic [0:0] {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } cfg_reg_e;

  // Position of one pixel in the frame, with its derived flags
  typedef struct packed {
    logic [ColW-1:0] col;
    logic            has_res;
    logic            interior;
    logic            last_row;
    logic            last_col;
  } pos_t;

  // Line store read data for one pixel
  typedef struct packed {
    logic [PixW-1:0] ctr;
    logic [PixW-1:0] up;
    logic [PixW-1:0] right;
  } taps_t;

endpackage

FILE: design/lapsh_pos.sv
`timescale 1ns / 1ps

module lapsh_pos (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  lapsh_pkg::cfg_reg_e          cfg_idx_i,
  input  logic [lapsh_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                         adv_i,
  output lapsh_pkg::pos_t              pos_o
);
  import lapsh_pkg::*;

  logic [WidthW-1:0] frame_width_q;
  logic [RowW-1:0]   frame_height_q;
  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;

  logic [WidthW-1:0] w_eff, w_m1;
  logic [RowW-1:0]   h_eff, h_m1;
  logic [ColW-1:0]   col_last, col_eff;
  logic [RowW-1:0]   row_eff;
  logic              last_col, last_row;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WidthReset;
      frame_height_q <= HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFrameWidth:  frame_width_q  <= cfg_data_i[WidthW-1:0];
        RegFrameHeight: frame_height_q <= cfg_data_i[RowW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame size to the supported range
  always_comb begin
    w_eff = frame_width_q;
    if (frame_width_q < WidthMin) begin
      w_eff = WidthMin;
    end else if (frame_width_q > WidthMax) begin
      w_eff = WidthMax;
    end
    h_eff = (frame_height_q < HeightMin) ? HeightMin : frame_height_q;
  end

  assign w_m1     = w_eff - WidthW'(1);
  assign h_m1     = h_eff - RowW'(1);
  assign col_last = w_m1[ColW-1:0];

  // Counters past the end of a shrunk frame act as the last column or row
  assign col_eff  = (col_q > col_last) ? col_last : col_q;
  assign row_eff  = (row_q > h_m1) ? h_m1 : row_q;
  assign last_col = (col_eff == col_last);
  assign last_row = (row_eff == h_m1);

  assign pos_o.col      = col_eff;
  assign pos_o.has_res  = (row_eff != '0);
  assign pos_o.interior = (row_eff >= RowW'(2)) && (col_eff != '0) && !last_col;
  assign pos_o.last_row = last_row;
  assign pos_o.last_col = last_col;

  // Advance raster position
  always_comb begin
    col_d = col_eff + ColW'(1);
    row_d = row_eff;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_eff + RowW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (adv_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: design/lapsh_lines.sv
`timescale 1ns / 1ps

module lapsh_lines (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [lapsh_pkg::ColW-1:0]  rd_col_i,
  input  logic                        wr_en_i,
  input  logic [lapsh_pkg::ColW-1:0]  wr_col_i,
  input  logic [lapsh_pkg::PixW-1:0]  wr_pix_i,
  output lapsh_pkg::taps_t            taps_o
);
  import lapsh_pkg::*;

  logic [PixW-1:0] above_mem [MaxWidth];
  logic [PixW-1:0] two_mem   [MaxWidth];
  logic [ColW-1:0] rd_next;
  taps_t           taps_q;

  // Right neighbor; wraps only on the last column, where it is unused
  assign rd_next = rd_col_i + ColW'(1);

  // Read all taps: two columns of the previous line, one of the line before that
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      taps_q.ctr   <= above_mem[rd_col_i];
      taps_q.right <= above_mem[rd_next];
      taps_q.up    <= two_mem[rd_col_i];
    end
    if (wr_en_i) begin
      above_mem[wr_col_i] <= wr_pix_i;
    end
  end

  // Line before that: shift in the center read for this column
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      two_mem[wr_col_i] <= taps_q.ctr;
    end
  end

  assign taps_o = taps_q;

endmodule

FILE: design/lapsh_kernel.sv
`timescale 1ns / 1ps

module lapsh_kernel (
  input  lapsh_pkg::taps_t            taps_i,
  input  logic [lapsh_pkg::PixW-1:0]  left_i,
  input  logic [lapsh_pkg::PixW-1:0]  down_i,
  input  logic                        interior_i,
  output logic [lapsh_pkg::PixW-1:0]  pix_o
);
  import lapsh_pkg::*;

  logic [AccW-1:0]        gain_ctr;
  logic [AccW-1:0]        nbr_sum;
  logic signed [AccW-1:0] acc_s;
  logic                   neg, over;

  // 5*center minus the four direct neighbors
  assign gain_ctr = AccW'(taps_i.ctr) * AccW'(SharpGain);
  assign nbr_sum  = AccW'(left_i) + AccW'(taps_i.right) + AccW'(taps_i.up) + AccW'(down_i);
  assign acc_s    = signed'(gain_ctr - nbr_sum);

  // Clamp to pixel range; border pixels give zero
  assign neg  = acc_s[AccW-1];
  assign over = |acc_s[AccW-2:PixW];

  always_comb begin
    if (!interior_i || neg) begin
      pix_o = '0;
    end else if (over) begin
      pix_o = '1;
    end else begin
      pix_o = acc_s[PixW-1:0];
    end
  end

endmodule

FILE: design/sharpen_3x3_laplacian.sv
`timescale 1ns / 1ps

// 3x3 Laplacian sharpening filter for 8-bit grayscale raster streams. Each
// interior pixel becomes 5*center minus its four direct neighbors, clamped to
// 0..255; border pixels come out as 0. Input pixel (r,c) releases output
// (r-1,c), row 0 releases nothing, and each pixel of the last row also
// releases a zero word for the last row; frame_done_o marks the frame's final
// word. One pixel is taken every clock while the output is not stalled; on
// the last row each pixel makes two words, so the single output register
// sets the pace there. The line store read registers at the same edge as a
// pixel is taken, and its sharpened first word then lands in the output
// register once that register is free. The line stores hold MaxWidth pixels
// each; the previous line is read at two columns per taken pixel. The user
// must write frame size on the config port only while no pixel is in flight;
// the block itself does not enforce this. A write takes effect at once.
module sharpen_3x3_laplacian (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [lapsh_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lapsh_pkg::PixW-1:0]  pixel_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lapsh_pkg::PixW-1:0]  pixel_out_o,
  output logic                        frame_done_o
);
  import lapsh_pkg::*;

  pos_t            pos;
  taps_t           taps;
  logic            accept;

  logic            s1_valid_q;
  logic            s1_phase_q;
  pos_t            s1_pos_q;
  logic [PixW-1:0] s1_pix_q;
  logic [PixW-1:0] left_q;
  logic            s1_done;
  logic            emit;
  logic [PixW-1:0] kern_pix;

  logic            out_valid_q;
  logic [PixW-1:0] out_pix_q, out_pix_d;
  logic            out_done_q, out_done_d;
  logic            out_free;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  lapsh_pos u_pos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_reg_e'(cfg_idx_i)),
    .cfg_data_i (cfg_data_i),
    .adv_i      (accept),
    .pos_o      (pos)
  );

  lapsh_lines u_lines (
    .clk_i    (clk_i),
    .rd_en_i  (accept),
    .rd_col_i (pos.col),
    .wr_en_i  (s1_done),
    .wr_col_i (s1_pos_q.col),
    .wr_pix_i (s1_pix_q),
    .taps_o   (taps)
  );

  lapsh_kernel u_kernel (
    .taps_i     (taps),
    .left_i     (left_q),
    .down_i     (s1_pix_q),
    .interior_i (s1_pos_q.interior),
    .pix_o      (kern_pix)
  );

  // Drain the held pixel: one word per free output slot, two on the last row
  assign emit    = s1_valid_q && s1_pos_q.has_res && out_free;
  assign s1_done = s1_valid_q &&
                   (!s1_pos_q.has_res || (emit && (!s1_pos_q.last_row || s1_phase_q)));
  assign in_stall_o = s1_valid_q && !s1_done;

  // Hold the accepted pixel and its position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_phase_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      s1_phase_q <= 1'b0;
    end else if (s1_done) begin
      s1_valid_q <= 1'b0;
      s1_phase_q <= 1'b0;
    end else if (emit) begin
      s1_phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pos_q <= pos;
      s1_pix_q <= pixel_in_i;
    end
    // Center of this pixel is the left neighbor of the next one
    if (s1_done) begin
      left_q <= taps.ctr;
    end
  end

  // Select word: sharpened pixel first, then the last-row zero word
  always_comb begin
    if (s1_phase_q) begin
      out_pix_d  = '0;
      out_done_d = s1_pos_q.last_col;
    end else begin
      out_pix_d  = kern_pix;
      out_done_d = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_pix_q  <= out_pix_d;
      out_done_q <= out_done_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = out_pix_q;
  assign frame_done_o = out_done_q;

  // Second word only exists for a held last-row pixel
  a_phase_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_phase_q |-> (s1_valid_q && s1_pos_q.last_row))
    else $error("second word phase outside last row");

  // End-of-frame word is always the zero border word
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> (pixel_out_o == '0))
    else $error("frame_done on nonzero word");

  // A last-row pixel leaves only after its second word
  a_last_row_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_done && s1_pos_q.last_row) |-> s1_phase_q)
    else $error("last-row pixel dropped before second word");

  // A taken pixel starts in its first phase
  a_accept_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (s1_valid_q && !s1_phase_q))
    else $error("accepted pixel not held");

endmodule

FILE: tb/sv/tb_sharpen_3x3_laplacian.sv
`timescale 1ns / 1ps

module tb_sharpen_3x3_laplacian;
  import lapsh_pkg::*;

  localparam int unsigned CycleLimit   = 2_000_000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned RandItems    = 200;

  typedef struct packed {
    logic [PixW-1:0] pix;
    logic            done;
  } out_word_t;

  localparam out_word_t ZeroWord = {8'h00, 1'b0};
  localparam out_word_t LastWord = {8'h00, 1'b1};
  localparam out_word_t FullWord = {8'hFF, 1'b0};

  typedef enum logic {DoPixel, DoWrite} stim_kind_e;

  typedef enum logic [1:0] {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_e;

  // One row of the directed table; typed rows carry their own expected words
  typedef struct packed {
    stim_kind_e  kind;
    cfg_reg_e    target;
    logic [15:0] data;
    logic        draw;
    logic [15:0] reps;
    logic        typed;
    logic [1:0]  n_words;
    out_word_t   w0;
    out_word_t   w1;
  } stim_row_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [0:0]          cfg_idx_i    = RegFrameWidth;
  logic [CfgW-1:0]     cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [PixW-1:0]     pixel_in_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [PixW-1:0]     pixel_out_o;
  logic                frame_done_o;

  sharpen_3x3_laplacian u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_in_i   (pixel_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_out_o  (pixel_out_o),
    .frame_done_o (frame_done_o)
  );

  // Filter state as the testbench sees it
  logic [PixW-1:0]   row_above     [MaxWidth];
  logic [PixW-1:0]   row_two_above [MaxWidth];
  int unsigned       cur_col    = 0;
  int unsigned       cur_row    = 0;
  logic [WidthW-1:0] width_reg  = WidthReset;
  logic [RowW-1:0]   height_reg = HeightReset;

  out_word_t   owed_words [$];
  stim_row_t   stim_tab [$];
  int unsigned mismatch_cnt = 0;
  int unsigned items_sent   = 0;
  int unsigned burst_left   = 0;
  int unsigned cycle_cnt    = 0;

  stall_mode_e stall_mode   = StallNone;
  int unsigned stall_hold   = 0;
  int unsigned stall_period = 2;

  always #5 clk_i = ~clk_i;

  function automatic int unsigned eff_width();
    if (width_reg < WidthMin) return WidthMin;
    if (width_reg > WidthMax) return WidthMax;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < HeightMin) return HeightMin;
    return height_reg;
  endfunction

  // Take one pixel: return the words it releases and advance the position
  function automatic int sharpen_step(input logic [PixW-1:0] px, output out_word_t first,
                                      output out_word_t second);
    int unsigned w, h, c, r;
    int          ctr, up, lft, rgt, acc, n;
    logic        last_c, last_r;
    w = eff_width();
    h = eff_height();
    c = (cur_col > w - 1) ? w - 1 : cur_col;
    r = (cur_row > h - 1) ? h - 1 : cur_row;
    last_c = (c == w - 1);
    last_r = (r == h - 1);
    first  = ZeroWord;
    second = ZeroWord;
    n = 0;
    if (r >= 1) begin
      // border words stay zero; interior words take the cross kernel
      if (r >= 2 && c != 0 && !last_c) begin
        ctr = row_above[c];
        up  = row_two_above[c];
        lft = row_two_above[c-1];
        rgt = row_above[c+1];
        acc = int'(SharpGain) * ctr - lft - rgt - up - int'(px);
        if (acc < 0) begin
          first.pix = '0;
        end else if (acc > 255) begin
          first.pix = '1;
        end else begin
          first.pix = acc[PixW-1:0];
        end
      end
      n = 1;
      // the last row also releases its own zero word
      if (last_r) begin
        second.done = last_c;
        n = 2;
      end
    end
    row_two_above[c] = row_above[c];
    row_above[c]     = px;
    if (last_c) begin
      cur_col = 0;
      cur_row = last_r ? 0 : r + 1;
    end else begin
      cur_col = c + 1;
      cur_row = r;
    end
    return n;
  endfunction

  function automatic logic [PixW-1:0] draw_pixel();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_height();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 2));
      1:       return 16'($urandom_range(7, 9));
      default: return 16'($urandom_range(3, 5));
    endcase
  endfunction

  // Upper data bits are random: only the low 13 reach the width register
  function automatic logic [15:0] pick_width();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 9))
      0:       v[12:0] = 13'($urandom_range(0, 2));
      1, 2:    v[12:0] = 13'($urandom_range(13, 24));
      default: v[12:0] = 13'($urandom_range(3, 12));
    endcase
    return v;
  endfunction

  function automatic void pix_row(input logic [PixW-1:0] px, input int unsigned reps,
                                  input logic draw, input logic typed, input int unsigned n,
                                  input out_word_t w0, input out_word_t w1);
    stim_row_t row;
    row = '0;
    row.kind    = DoPixel;
    row.data    = {8'h00, px};
    row.reps    = 16'(reps);
    row.draw    = draw;
    row.typed   = typed;
    row.n_words = 2'(n);
    row.w0      = w0;
    row.w1      = w1;
    stim_tab.push_back(row);
  endfunction

  function automatic void reg_row(input cfg_reg_e target, input logic [15:0] value);
    stim_row_t row;
    row = '0;
    row.kind   = DoWrite;
    row.target = target;
    row.data   = value;
    stim_tab.push_back(row);
  endfunction

  // Drop valid and hold until every owed word is out and the pipe is quiet
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e target, input logic [15:0] value);
    drain_outputs();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= target;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (target == RegFrameWidth) begin
      width_reg = value[WidthW-1:0];
    end else begin
      height_reg = value;
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Send one pixel word in bursts with random gaps, then queue its words
  task automatic push_pixel(input logic [PixW-1:0] px, input logic typed,
                            input logic [1:0] n_typed, input out_word_t t0,
                            input out_word_t t1);
    int unsigned gap;
    int          n;
    out_word_t   p0, p1;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      case ($urandom_range(0, 7))
        0, 1, 2, 3: gap = 0;
        4, 5, 6:    gap = $urandom_range(1, 4);
        default:    gap = $urandom_range(5, 24);
      endcase
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    pixel_in_i <= px;
    do @(posedge clk_i); while (in_stall_o);
    n = sharpen_step(px, p0, p1);
    if (typed) begin
      if (n_typed > 0) owed_words.push_back(t0);
      if (n_typed > 1) owed_words.push_back(t1);
    end else begin
      if (n > 0) owed_words.push_back(p0);
      if (n > 1) owed_words.push_back(p1);
    end
    items_sent++;
  endtask

  task automatic push_random();
    push_pixel(draw_pixel(), 1'b0, 2'd0, ZeroWord, ZeroWord);
  endtask

  task automatic finish_frame();
    do push_random(); while (cur_col != 0 || cur_row != 0);
  endtask

  // Check each accepted output word against the oldest owed word
  always @(posedge clk_i) begin : check_words
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got pix=%0d done=%0b",
                 $time, pixel_out_o, frame_done_o);
        mismatch_cnt++;
      end else begin
        want = owed_words.pop_front();
        if (want.pix !== pixel_out_o) begin
          $display("%0t: pixel_out expected %0d, got %0d", $time, want.pix, pixel_out_o);
          mismatch_cnt++;
        end
        if (want.done !== frame_done_o) begin
          $display("%0t: frame_done expected %0b, got %0b", $time, want.done, frame_done_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // Receiver stalls in stretches of changing character
  always @(posedge clk_i) begin
    if (stall_hold == 0) begin
      stall_mode   = stall_mode_e'($urandom_range(0, 3));
      stall_hold   = $urandom_range(16, 256);
      stall_period = $urandom_range(2, 7);
    end else begin
      stall_hold--;
    end
    case (stall_mode)
      StallNone:  out_stall_i <= 1'b0;
      StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:    out_stall_i <= ((cycle_cnt % stall_period) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned base, cut;
    logic [15:0] wdata;

    // Reset size: a full 640-pixel first row gives nothing, the next pixel a border zero
    pix_row(8'h5A, 640, 1'b0, 1'b1, 0, ZeroWord, ZeroWord);
    pix_row(8'h00, 1, 1'b0, 1'b1, 1, ZeroWord, ZeroWord);
    // shrink to 3x3 in the middle of the frame
    reg_row(RegFrameWidth, 16'd3);
    pix_row(8'hFF, 1, 1'b0, 1'b1, 1, ZeroWord, ZeroWord);
    reg_row(RegFrameHeight, 16'd3);
    pix_row(8'h00, 1, 1'b0, 1'b1, 1, ZeroWord, ZeroWord);
    pix_row(8'h00, 1, 1'b0, 1'b1, 2, ZeroWord, ZeroWord);
    // bright center over dark neighbors clamps high
    pix_row(8'h00, 1, 1'b0, 1'b1, 2, FullWord, ZeroWord);
    pix_row(8'h00, 1, 1'b0, 1'b1, 2, ZeroWord, LastWord);
    // dark center in a bright ring clamps to zero
    pix_row(8'hFF, 3, 1'b0, 1'b1, 0, ZeroWord, ZeroWord);
    pix_row(8'hFF, 1, 1'b0, 1'b1, 1, ZeroWord, ZeroWord);
    pix_row(8'h00, 1, 1'b0, 1'b1, 1, ZeroWord, ZeroWord);
    pix_row(8'hFF, 1, 1'b0, 1'b1, 1, ZeroWord, ZeroWord);
    pix_row(8'hFF, 2, 1'b0, 1'b1, 2, ZeroWord, ZeroWord);
    pix_row(8'hFF, 1, 1'b0, 1'b1, 2, ZeroWord, LastWord);
    // undersized registers act as 3x3
    reg_row(RegFrameWidth, 16'd0);
    reg_row(RegFrameHeight, 16'd2);
    pix_row(8'h00, 9, 1'b1, 1'b0, 0, ZeroWord, ZeroWord);
    // width bits above the register are dropped
    reg_row(RegFrameWidth, 16'hE005);
    reg_row(RegFrameHeight, 16'd4);
    pix_row(8'h00, 20, 1'b1, 1'b0, 0, ZeroWord, ZeroWord);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (stim_tab[i]) begin
      if (stim_tab[i].kind == DoWrite) begin
        write_reg(stim_tab[i].target, stim_tab[i].data);
      end else begin
        for (int k = 0; k < stim_tab[i].reps; k++)
          push_pixel(stim_tab[i].draw ? draw_pixel() : stim_tab[i].data[PixW-1:0],
                     stim_tab[i].typed, stim_tab[i].n_words, stim_tab[i].w0, stim_tab[i].w1);
      end
    end

    // Tallest height, then cut to 3 rows while deep in the frame
    write_reg(RegFrameWidth, 16'd4);
    write_reg(RegFrameHeight, 16'hFFFF);
    repeat (4 * 7 + 2) push_random();
    write_reg(RegFrameHeight, 16'd2);
    finish_frame();

    // Random frames, some cut partway and resized
    base = items_sent;
    while (items_sent - base < RandItems) begin
      if ($urandom_range(0, 3) != 0) write_reg(RegFrameWidth, pick_width());
      if ($urandom_range(0, 3) != 0) write_reg(RegFrameHeight, pick_height());
      if ($urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, eff_width() * eff_height() - 1);
        repeat (cut) push_random();
        // only shrink the width mid-frame so the line stores stay written
        if ($urandom_range(0, 1) != 0) begin
          wdata = 16'($urandom);
          wdata[12:0] = 13'($urandom_range(0, eff_width()));
          write_reg(RegFrameWidth, wdata);
        end
        if ($urandom_range(0, 1) != 0) write_reg(RegFrameHeight, pick_height());
        finish_frame();
      end else begin
        repeat ($urandom_range(1, 2)) finish_frame();
      end
      if ($urandom_range(0, 5) == 0) drain_outputs();
    end

    drain_outputs();
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/lapsh_pkg.sv
design/lapsh_pos.sv
design/lapsh_lines.sv
design/lapsh_kernel.sv
design/sharpen_3x3_laplacian.sv
tb/sv/tb_sharpen_3x3_laplacian.sv
